// ----- rtl/alcd_pkg.sv -----
package alcd_pkg;

    localparam int NUM_WAYS   = 16;
    localparam int LINE_BYTES = 256;

    localparam int ADDR_W    = 28;
    localparam int OFFSET_W  = $clog2(LINE_BYTES);
    localparam int LINE_W    = ADDR_W - OFFSET_W;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int KIND_W    = 2;
    localparam int WAY_OUT_W = 4;
    localparam int FILL_W    = 20;

    localparam logic [KIND_W-1:0] KIND_ACCESS     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFRESH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALIDATE = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_FILL,
        CMD_REFRESH,
        CMD_INVAL
    } cmd_op_t;

    // Update broadcast to every cell; way-specific ops act only in the addressed cell.
    typedef struct packed {
        cmd_op_t             op;
        logic [WAY_W-1:0]    way;
        logic [LINE_W-1:0]   tag;
    } cmd_t;

    // Lookup word that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic                active;
        logic [LINE_W-1:0]   line;
        logic                hit_found;
        logic [WAY_W-1:0]    hit_way;
        logic                inv_found;
        logic [WAY_W-1:0]    inv_way;
        logic                na_found;
        logic [WAY_W-1:0]    na_way;
    } probe_t;

endpackage

// ----- rtl/alcd_cell.sv -----
module alcd_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [alcd_pkg::WAY_W-1:0]  cell_id,
    input  alcd_pkg::probe_t            up_probe,
    output alcd_pkg::probe_t            down_probe,
    input  alcd_pkg::cmd_t              cmd
);

    logic [alcd_pkg::LINE_W-1:0] tag_reg;
    logic [alcd_pkg::LINE_W-1:0] tag_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        acc_reg;
    logic                        acc_next;
    alcd_pkg::probe_t            probe_reg;
    alcd_pkg::probe_t            probe_next;

    // Each cell records itself as the first hit, invalid or not-accessed way only
    // when no earlier cell has already claimed that slot.
    always_comb
    begin
        probe_next = up_probe;
        if (up_probe.active)
        begin
            if (!up_probe.hit_found && valid_reg && (tag_reg == up_probe.line))
            begin
                probe_next.hit_found = 1'b1;
                probe_next.hit_way   = cell_id;
            end
            if (!up_probe.inv_found && !valid_reg)
            begin
                probe_next.inv_found = 1'b1;
                probe_next.inv_way   = cell_id;
            end
            if (!up_probe.na_found && !acc_reg)
            begin
                probe_next.na_found = 1'b1;
                probe_next.na_way   = cell_id;
            end
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        acc_next   = acc_reg;
        case (cmd.op)
            alcd_pkg::CMD_HIT:
            begin
                if (cmd.way == cell_id)
                begin
                    acc_next = 1'b1;
                end
            end
            alcd_pkg::CMD_FILL:
            begin
                if (cmd.way == cell_id)
                begin
                    tag_next   = cmd.tag;
                    valid_next = 1'b1;
                    acc_next   = 1'b1;
                end
            end
            alcd_pkg::CMD_REFRESH:
            begin
                if (!acc_reg)
                begin
                    valid_next = 1'b0;
                    tag_next   = '0;
                end
                acc_next = 1'b0;
            end
            alcd_pkg::CMD_INVAL:
            begin
                tag_next   = '0;
                valid_next = 1'b0;
                acc_next   = 1'b0;
            end
            default:
            begin
                tag_next   = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
            acc_reg   <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            tag_reg   <= tag_next;
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
            probe_reg <= probe_next;
        end
    end

    assign down_probe = probe_reg;

endmodule

// ----- rtl/assoc_line_cache_directory.sv -----
// Directory of a fully associative cache (16 ways of 256-byte lines, not-recently-used
// replacement), built as a chain of way cells. An access sends a lookup word down the
// chain one cell per cycle; at its end the way is picked and registered, and once the
// result register is free or being drained the chosen cell is updated and the result
// loaded. Refresh and invalidate update all cells at once; for them and the unused
// kind the result is loaded on acceptance. One item is in the block at a time; a new
// item is taken once the lookup is done and the result register is free or draining.
module assoc_line_cache_directory (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [alcd_pkg::KIND_W-1:0]     kind,
    input  logic [alcd_pkg::ADDR_W-1:0]     byte_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [alcd_pkg::WAY_OUT_W-1:0]  way,
    output logic                            fill_needed,
    output logic [alcd_pkg::FILL_W-1:0]     fill_line
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                         state_reg;
    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [alcd_pkg::WAY_OUT_W-1:0] way_reg;
    logic                           fill_needed_reg;
    logic [alcd_pkg::FILL_W-1:0]    fill_line_reg;
    logic                           res_hit_reg;
    logic [alcd_pkg::WAY_W-1:0]     res_way_reg;
    logic [alcd_pkg::LINE_W-1:0]    res_line_reg;

    alcd_pkg::probe_t               probe_w [0:alcd_pkg::NUM_WAYS];
    logic [alcd_pkg::NUM_WAYS:0]    act_vec;
    alcd_pkg::probe_t               last_probe;
    alcd_pkg::cmd_t                 cmd;
    logic                           out_free;
    logic                           accept;
    logic                           out_load;
    logic [alcd_pkg::WAY_W-1:0]     victim;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign out_load = (accept && (kind != alcd_pkg::KIND_ACCESS))
                   || ((state_reg == S_DONE) && out_free);

    always_comb
    begin
        probe_w[0]        = '0;
        probe_w[0].active = accept && (kind == alcd_pkg::KIND_ACCESS);
        probe_w[0].line   = byte_address[alcd_pkg::ADDR_W-1:alcd_pkg::OFFSET_W];
    end

    genvar gi;
    generate
        for (gi = 0; gi < alcd_pkg::NUM_WAYS; gi++)
        begin : g_cell
            alcd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_id    (alcd_pkg::WAY_W'(gi)),
                .up_probe   (probe_w[gi]),
                .down_probe (probe_w[gi+1]),
                .cmd        (cmd)
            );
        end
        for (gi = 0; gi <= alcd_pkg::NUM_WAYS; gi++)
        begin : g_act
            assign act_vec[gi] = probe_w[gi].active;
        end
    endgenerate

    assign last_probe = probe_w[alcd_pkg::NUM_WAYS];

    // Victim order: first invalid way, then first way not accessed, else way 0.
    always_comb
    begin
        if (last_probe.inv_found)
        begin
            victim = last_probe.inv_way;
        end
        else if (last_probe.na_found)
        begin
            victim = last_probe.na_way;
        end
        else
        begin
            victim = '0;
        end
    end

    always_comb
    begin
        cmd = '0;
        if ((state_reg == S_DONE) && out_free)
        begin
            cmd.op  = res_hit_reg ? alcd_pkg::CMD_HIT : alcd_pkg::CMD_FILL;
            cmd.way = res_way_reg;
            cmd.tag = res_line_reg;
        end
        else if (accept)
        begin
            case (kind)
                alcd_pkg::KIND_REFRESH:    cmd.op = alcd_pkg::CMD_REFRESH;
                alcd_pkg::KIND_INVALIDATE: cmd.op = alcd_pkg::CMD_INVAL;
                default:                   cmd.op = alcd_pkg::CMD_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            way_reg         <= '0;
            fill_needed_reg <= 1'b0;
            fill_line_reg   <= '0;
            res_hit_reg     <= 1'b0;
            res_way_reg     <= '0;
            res_line_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (kind == alcd_pkg::KIND_ACCESS)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            out_valid_reg   <= 1'b1;
                            hit_reg         <= 1'b0;
                            way_reg         <= '0;
                            fill_needed_reg <= 1'b0;
                            fill_line_reg   <= '0;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last_probe.active)
                    begin
                        res_hit_reg  <= last_probe.hit_found;
                        res_way_reg  <= last_probe.hit_found ? last_probe.hit_way : victim;
                        res_line_reg <= last_probe.line;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        hit_reg         <= res_hit_reg;
                        way_reg         <= alcd_pkg::WAY_OUT_W'(res_way_reg);
                        fill_needed_reg <= !res_hit_reg;
                        fill_line_reg   <= res_hit_reg ? '0 : alcd_pkg::FILL_W'(res_line_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign way         = way_reg;
    assign fill_needed = fill_needed_reg;
    assign fill_line   = fill_line_reg;

    // Only one lookup word may travel the chain at a time.
    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one lookup word in the cell chain");

    // The lookup word leaves the chain only while the controller waits for it.
    a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last_probe.active |-> (state_reg == S_SCAN))
        else $error("lookup word finished outside the scan state");

    // Every update of the cells goes together with a result entering the output register.
    a_cmd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != alcd_pkg::CMD_NONE) |=> out_valid_reg)
        else $error("cell update without a result word");

endmodule

// ----- dv/tb_assoc_line_cache_directory.sv -----
module tb_assoc_line_cache_directory;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOT_LINES       = 24;

    localparam logic [alcd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        bit                           hit;
        bit [alcd_pkg::WAY_OUT_W-1:0] way;
        bit                           fill_needed;
        bit [alcd_pkg::FILL_W-1:0]    fill_line;
    } dir_result_t;

    // Mirror of the tag directory plus the queue of results still owed by the block.
    class line_directory_model;
        bit [alcd_pkg::LINE_W-1:0] tags [alcd_pkg::NUM_WAYS];
        bit                        valid [alcd_pkg::NUM_WAYS];
        bit                        accessed [alcd_pkg::NUM_WAYS];
        dir_result_t               expected_results [$];
        int                        mismatch_count;

        function new();
            clear_ways();
            mismatch_count = 0;
        endfunction

        function void clear_ways();
            for (int w = 0; w < alcd_pkg::NUM_WAYS; w++)
            begin
                tags[w]     = '0;
                valid[w]    = 1'b0;
                accessed[w] = 1'b0;
            end
        endfunction

        function int pick_victim();
            int victim;
            victim = -1;
            for (int w = 0; w < alcd_pkg::NUM_WAYS; w++)
                if (victim < 0 && !valid[w])
                    victim = w;
            for (int w = 0; w < alcd_pkg::NUM_WAYS; w++)
                if (victim < 0 && !accessed[w])
                    victim = w;
            if (victim < 0)
                victim = 0;
            return victim;
        endfunction

        function void note_request(logic [alcd_pkg::KIND_W-1:0] k,
                                   logic [alcd_pkg::ADDR_W-1:0] addr);
            dir_result_t               res;
            bit [alcd_pkg::LINE_W-1:0] line;
            int                        found;
            int                        victim;
            res = '{default: '0};
            line = addr[alcd_pkg::ADDR_W-1:alcd_pkg::OFFSET_W];
            found = -1;
            case (k)
                alcd_pkg::KIND_REFRESH:
                begin
                    for (int w = 0; w < alcd_pkg::NUM_WAYS; w++)
                    begin
                        if (!accessed[w])
                        begin
                            valid[w] = 1'b0;
                            tags[w]  = '0;
                        end
                        accessed[w] = 1'b0;
                    end
                end
                alcd_pkg::KIND_INVALIDATE:
                    clear_ways();
                alcd_pkg::KIND_ACCESS:
                begin
                    for (int w = 0; w < alcd_pkg::NUM_WAYS; w++)
                        if (found < 0 && valid[w] && tags[w] == line)
                            found = w;
                    if (found >= 0)
                    begin
                        accessed[found] = 1'b1;
                        res.hit = 1'b1;
                        res.way = alcd_pkg::WAY_OUT_W'(found);
                    end
                    else
                    begin
                        victim = pick_victim();
                        tags[victim]     = line;
                        valid[victim]    = 1'b1;
                        accessed[victim] = 1'b1;
                        res.way         = alcd_pkg::WAY_OUT_W'(victim);
                        res.fill_needed = 1'b1;
                        res.fill_line   = alcd_pkg::FILL_W'(line);
                    end
                end
                default:
                begin
                end
            endcase
            expected_results.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] %s", $time, msg);
            mismatch_count++;
        endtask

        task check_response(bit got_hit, bit [alcd_pkg::WAY_OUT_W-1:0] got_way,
                            bit got_fill, bit [alcd_pkg::FILL_W-1:0] got_line);
            dir_result_t want;
            if (expected_results.size() == 0)
            begin
                report("result word arrived with nothing outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got_hit != want.hit)
                report($sformatf("hit: got %0d want %0d", got_hit, want.hit));
            if (got_way != want.way)
                report($sformatf("way: got %0d want %0d", got_way, want.way));
            if (got_fill != want.fill_needed)
                report($sformatf("fill_needed: got %0d want %0d", got_fill, want.fill_needed));
            if (got_line != want.fill_line)
                report($sformatf("fill_line: got %05h want %05h", got_line, want.fill_line));
        endtask
    endclass

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [alcd_pkg::KIND_W-1:0]    kind         = alcd_pkg::KIND_ACCESS;
    logic [alcd_pkg::ADDR_W-1:0]    byte_address = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic                           hit;
    logic [alcd_pkg::WAY_OUT_W-1:0] way;
    logic                           fill_needed;
    logic [alcd_pkg::FILL_W-1:0]    fill_line;

    line_directory_model dir_model;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    assoc_line_cache_directory uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .way          (way),
        .fill_needed  (fill_needed),
        .fill_line    (fill_line)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            dir_model.note_request(kind, byte_address);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            dir_model.check_response(hit, way, fill_needed, fill_line);
    end

    // Result side: random stalls, plus one long hold-off so the block backs up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_word(logic [alcd_pkg::KIND_W-1:0] k, logic [alcd_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        byte_address <= addr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task run_directed();
        bit [alcd_pkg::LINE_W-1:0] ln;
        send_word(KIND_UNUSED, alcd_pkg::ADDR_W'($urandom));
        send_word(alcd_pkg::KIND_REFRESH, alcd_pkg::ADDR_W'($urandom));
        send_word(alcd_pkg::KIND_ACCESS, 28'h0000000);
        send_word(alcd_pkg::KIND_ACCESS, 28'h00000FF);
        send_word(alcd_pkg::KIND_ACCESS, 28'hFFFFFFF);
        for (int i = 2; i < alcd_pkg::NUM_WAYS; i++)
        begin
            ln = alcd_pkg::LINE_W'(i * 'h0F0F1);
            send_word(alcd_pkg::KIND_ACCESS, {ln, alcd_pkg::OFFSET_W'($urandom)});
        end
        // Every way is valid and marked, so the miss falls back to way 0.
        send_word(alcd_pkg::KIND_ACCESS, {20'hABCDE, alcd_pkg::OFFSET_W'($urandom)});
        send_word(alcd_pkg::KIND_REFRESH, alcd_pkg::ADDR_W'($urandom));
        send_word(alcd_pkg::KIND_ACCESS, {20'hABCDE, alcd_pkg::OFFSET_W'($urandom)});
        // Way 0 is marked again; the next miss must take the first unmarked way.
        send_word(alcd_pkg::KIND_ACCESS, {20'h13579, alcd_pkg::OFFSET_W'($urandom)});
        send_word(alcd_pkg::KIND_INVALIDATE, alcd_pkg::ADDR_W'($urandom));
        send_word(alcd_pkg::KIND_ACCESS, 28'hFFFFFFF);
    endtask

    // Mostly accesses drawn from a working set a bit larger than the directory, so that hits,
    // evictions and refresh survivors all occur; the rest are other kinds or random accesses.
    task run_random(int count);
        bit [alcd_pkg::LINE_W-1:0] hot [HOT_LINES];
        int                        r;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                for (int h = 0; h < HOT_LINES; h++)
                    hot[h] = alcd_pkg::LINE_W'($urandom);
            r = $urandom_range(99);
            if (r < 3)
                send_word(KIND_UNUSED, alcd_pkg::ADDR_W'($urandom));
            else if (r < 5)
                send_word(alcd_pkg::KIND_INVALIDATE, alcd_pkg::ADDR_W'($urandom));
            else if (r < 13)
                send_word(alcd_pkg::KIND_REFRESH, alcd_pkg::ADDR_W'($urandom));
            else if ($urandom_range(3) != 0)
                send_word(alcd_pkg::KIND_ACCESS,
                          {hot[$urandom_range(HOT_LINES - 1)],
                           alcd_pkg::OFFSET_W'($urandom)});
            else
                send_word(alcd_pkg::KIND_ACCESS, alcd_pkg::ADDR_W'($urandom));
        end
    endtask

    initial
    begin
        int waited;
        dir_model = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(212);

        send_idle_pct  = 64;
        recv_stall_pct = 0;
        run_random(212);

        send_idle_pct  = 0;
        recv_stall_pct = 64;
        hold_req       = 1'b1;
        run_random(213);

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        run_random(213);
        in_valid <= 1'b0;

        waited = 0;
        while (dir_model.expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (dir_model.expected_results.size() != 0)
            dir_model.report($sformatf("%0d result words never arrived",
                                       dir_model.expected_results.size()));

        if (dir_model.mismatch_count == 0)
            $display("** assoc_line_cache_directory: PASSED **");
        else
            $display("** assoc_line_cache_directory: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** assoc_line_cache_directory: FAILED **");
        $finish;
    end

endmodule
